[sv/sdma_pkg.sv]
// Shared types and constants for the single-channel word DMA controller.
package sdma_pkg;

    localparam int DATA_W          = 32;
    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int CMD_DEPTH_DEF   = 2;
    localparam int RES_DEPTH_DEF   = 2;
    localparam int PADDR_W         = 3;
    localparam logic [DATA_W-1:0] WORD_BYTES = DATA_W'(4);

    // configuration register index, taken from paddr word bits
    localparam logic CFG_BASE_ADDR = 1'b0;

    typedef enum logic [1:0] {
        K_REG_WR  = 2'd0,
        K_TICK    = 2'd1,
        K_RD_DATA = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_SOURCE = 2'd0,
        REG_TARGET = 2'd1,
        REG_SIZE   = 2'd2,
        REG_START  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_READ  = 4'b0010,
        PH_WRITE = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] bus_address;
        logic [DATA_W-1:0] write_value;
        logic [DATA_W-1:0] read_return;
    } t_in_item;

    typedef struct packed {
        logic              master_valid;
        logic              master_is_write;
        logic [DATA_W-1:0] master_address;
        logic [DATA_W-1:0] master_wdata;
        logic              interrupt_level;
        logic              bad_access;
    } t_result;

    // classified item as held in the command queue
    typedef struct packed {
        t_kind             kind;
        t_reg_idx          reg_idx;
        logic              bad;
        logic [DATA_W-1:0] data;
    } t_cmd;

endpackage

[sv/simple_dma_controller_top.sv]
// An item is decoded by the front end, held in the command queue, stepped by the engine and stored in the result queue.
// Throughput: one item per clock while a command is queued and the result queue has room.
// Command and result queues decouple input, engine and output; each side stalls on its own.
// Reset (i_rst_n low, synchronous): queues empty, phase idle, all registers and base 0.
module simple_dma_controller_top #(
    parameter int ADDR_WIDTH = sdma_pkg::ADDR_WIDTH_DEF,
    parameter int CMD_DEPTH  = sdma_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = sdma_pkg::RES_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  sdma_pkg::t_in_item            i_item,
    input  logic                          pop,
    output logic                          empty,
    output sdma_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdma_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdma_pkg::DATA_W-1:0]   pwdata,
    output logic [sdma_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sdma_pkg::*;

    logic [DATA_W-1:0] r_base_addr;
    t_cmd              front_cmd;
    t_cmd              eng_cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    t_result           eng_res;
    logic              res_push;
    logic              res_full;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_BASE_ADDR) ? r_base_addr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_BASE_ADDR) begin
            r_base_addr <= pwdata;
        end
    end

    sdma_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_item      (i_item),
        .i_base_addr (r_base_addr),
        .o_cmd       (front_cmd)
    );

    sdma_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (eng_cmd),
        .o_empty (cmd_empty)
    );

    sdma_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (eng_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (eng_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    sdma_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    // a write request is always a valid request
    a_write_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.master_is_write |-> o_result.master_valid)
        else $error("write flag without a request");

    // a rejected register write never issues a bus request
    a_bad_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.bad_access |-> !o_result.master_valid)
        else $error("bad access together with a request");

    // engine only steps when there is room for its item
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full && !cmd_empty)
        else $error("engine stepped without room or command");
`endif

endmodule

[sv/sdma_fifo.sv]
// Small register-based first-in first-out queue.
module sdma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/sdma_front.sv]
// Front end: decodes an incoming item into a command for the transfer engine.
module sdma_front #(
    parameter int ADDR_WIDTH = 32
) (
    input  sdma_pkg::t_in_item           i_item,
    input  logic [sdma_pkg::DATA_W-1:0] i_base_addr,
    output sdma_pkg::t_cmd               o_cmd
);
    import sdma_pkg::*;

    logic [ADDR_WIDTH-1:0] bus_a;
    logic [ADDR_WIDTH-1:0] base_a;
    logic [ADDR_WIDTH-1:0] offset;

    // offset wraps at the slave address width
    assign bus_a  = ADDR_WIDTH'(i_item.bus_address);
    assign base_a = ADDR_WIDTH'(i_base_addr);
    assign offset = bus_a - base_a;

    always_comb begin
        o_cmd         = '0;
        o_cmd.kind    = t_kind'(i_item.kind);
        o_cmd.reg_idx = t_reg_idx'(offset[3:2]);
        o_cmd.bad     = (t_kind'(i_item.kind) == K_REG_WR) && (|offset[ADDR_WIDTH-1:4]);
        o_cmd.data    = (t_kind'(i_item.kind) == K_RD_DATA) ? i_item.read_return
                                                             : i_item.write_value;
    end

endmodule

[sv/sdma_engine.sv]
// Back end: control registers, transfer sequencer and result generation.
module sdma_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdma_pkg::t_cmd   i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    output sdma_pkg::t_result o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);
    import sdma_pkg::*;

    t_phase            r_phase, n_phase;
    logic [DATA_W-1:0] r_source, n_source;
    logic [DATA_W-1:0] r_target, n_target;
    logic [DATA_W-1:0] r_size, n_size;
    logic [DATA_W-1:0] r_start, n_start;
    logic [DATA_W-1:0] r_buf, n_buf;
    logic              r_irq, n_irq;
    logic              step;

    assign step       = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = step;
    assign o_res_push = step;

    always_comb begin
        n_phase  = r_phase;
        n_source = r_source;
        n_target = r_target;
        n_size   = r_size;
        n_start  = r_start;
        n_buf    = r_buf;
        n_irq    = r_irq;
        o_res    = '0;

        unique case (i_cmd.kind)
            K_REG_WR: begin
                if (i_cmd.bad) begin
                    o_res.bad_access = 1'b1;
                end else begin
                    unique case (i_cmd.reg_idx)
                        REG_SOURCE: n_source = i_cmd.data;
                        REG_TARGET: n_target = i_cmd.data;
                        REG_SIZE:   n_size   = i_cmd.data;
                        REG_START:  n_start  = i_cmd.data;
                        default:    n_start  = r_start;
                    endcase
                end
            end
            K_TICK: begin
                unique case (r_phase)
                    PH_IDLE, PH_READ: begin
                        if (r_phase == PH_READ || r_start != '0) begin
                            o_res.master_valid   = 1'b1;
                            o_res.master_address = r_source;
                            n_source             = r_source + WORD_BYTES;
                            n_phase              = PH_WRITE;
                        end
                    end
                    PH_WRITE: begin
                        o_res.master_valid    = 1'b1;
                        o_res.master_is_write = 1'b1;
                        o_res.master_address  = r_target;
                        o_res.master_wdata    = r_buf;
                        n_target              = r_target + WORD_BYTES;
                        // size is tested before the decrement
                        n_phase               = (r_size == '0) ? PH_DONE : PH_READ;
                        n_size                = r_size - WORD_BYTES;
                    end
                    PH_DONE: begin
                        if (r_start == '0) begin
                            n_phase = PH_IDLE;
                            n_irq   = 1'b0;
                        end else begin
                            n_irq   = 1'b1;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
            K_RD_DATA: n_buf = i_cmd.data;
            K_NONE:    n_buf = r_buf;
            default:   n_buf = r_buf;
        endcase

        o_res.interrupt_level = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_source <= '0;
            r_target <= '0;
            r_size   <= '0;
            r_start  <= '0;
            r_buf    <= '0;
            r_irq    <= 1'b0;
        end else if (step) begin
            r_phase  <= n_phase;
            r_source <= n_source;
            r_target <= n_target;
            r_size   <= n_size;
            r_start  <= n_start;
            r_buf    <= n_buf;
            r_irq    <= n_irq;
        end
    end

endmodule
